### hdl/c8_pkg.sv
// c8_pkg: shared constants and types of the chip-8 instruction core
// no dependencies
`default_nettype none
package c8_pkg;
   localparam int MEM_BYTES      = 4096;
   localparam int PROGRAM_START  = 512;
   localparam int DISPLAY_WIDTH  = 64;
   localparam int DISPLAY_HEIGHT = 32;
   localparam int GLYPH_BYTES    = 5;
   localparam int STACK_DEPTH    = 16;
   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int ROW_AW = $clog2(DISPLAY_HEIGHT);
   localparam int COL_AW = $clog2(DISPLAY_WIDTH);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam logic [7:0] RND_RESET = 8'd111;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_EXEC  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_MEMWR, OP_FETCH_HI, OP_FETCH_LO, OP_DECODE, OP_ROWRD, OP_CLR_ROW,
      OP_SPR_RD, OP_SPR_FRD, OP_SPR_WR, OP_BCD_WR, OP_STR_WR, OP_LD_RD, OP_LD_WR,
      OP_RET_RD, OP_RET_WR, OP_LOAD_PC
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [3:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic [15:0] opcode;
      logic        multi;
      logic [3:0]  steps;
      logic        key_wait;
   } status_type;
endpackage
`default_nettype wire

### hdl/c8_ram.sv
// c8_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module c8_ram #(parameter int WIDTH = 8, parameter int DEPTH = 16) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

### hdl/c8_datapath.sv
// c8_datapath: registers, memories, display and instruction execution
// depends on c8_pkg and c8_ram
`default_nettype none
module c8_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire c8_pkg::cmd_type   cmd,
   input  wire logic [1:0]        func,
   input  wire logic [11:0]       mem_address,
   input  wire logic [7:0]        mem_data,
   input  wire logic [15:0]       keys_down,
   input  wire logic [4:0]        row_select,
   input  wire logic [7:0]        rnd_value,
   output c8_pkg::status_type     status,
   output logic [11:0]            pc_out,
   output logic [63:0]            row_pixels,
   output logic [7:0]             flag_reg,
   output logic                   sound_on
);
   import c8_pkg::*;

   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [11:0] i_ff, i_in, pc_ff, pc_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [15:0] op_ff, op_in;
   logic [63:0] row_ff, row_in;
   logic        hit_ff, hit_in, kw_ff, kw_in;
   logic [DISPLAY_HEIGHT-1:0] fvalid_ff, fvalid_in;

   logic [3:0]  x, y, n;
   logic [7:0]  kk, vx, vy, spr_x, spr_y;
   assign x  = op_ff[11:8];
   assign y  = op_ff[7:4];
   assign n  = op_ff[3:0];
   assign kk = op_ff[7:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];
   assign spr_x = vx;
   assign spr_y = vy;

   logic             m_we;
   logic [MEM_AW-1:0] m_addr;
   logic [7:0]       m_wd, m_rd;
   c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

   logic             f_we;
   logic [ROW_AW-1:0] f_addr;
   logic [63:0]      f_wd, f_rd, f_row;
   c8_ram #(.WIDTH(64), .DEPTH(DISPLAY_HEIGHT)) u_frame (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

   logic [11:0] pc2;
   assign pc2 = pc_ff + 12'd2;

   logic             s_we;
   logic [SP_W-1:0]  s_addr;
   logic [11:0]      s_rd;
   c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(pc2), .rdata(s_rd));

   logic [ROW_AW-1:0] rd_row_ff, rd_row_in;
   assign f_row = fvalid_ff[rd_row_ff] ? f_rd : 64'd0;

   logic [7:0]  bcd_h, bcd_t, bcd_o, bcd_d;
   logic [3:0]  low_key;
   logic [63:0] spr_mask;
   logic [ROW_AW-1:0] spr_row;

   always_comb begin
      bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
      bcd_d = vx - 8'(bcd_h * 8'd100);
      bcd_t = 8'((16'(bcd_d) * 16'd205) >> 11);
      bcd_o = bcd_d - 8'(bcd_t * 8'd10);
      low_key = 4'd0;
      for (int k = 15; k >= 0; k--) if (keys_down[k]) low_key = 4'(k);
   end

   always_comb begin
      logic [COL_AW-1:0] col;
      spr_mask = 64'd0;
      for (int c = 0; c < 8; c++) begin
         col = COL_AW'((32'(spr_x) + 32'(c)) % DISPLAY_WIDTH);
         if (m_rd[7-c]) spr_mask[63-col] = 1'b1;
      end
      spr_row = ROW_AW'((32'(spr_y) + 32'(cmd.cnt)) % DISPLAY_HEIGHT);
   end

   always_comb begin
      for (int r = 0; r < 16; r++) v_in[r] = v_ff[r];
      i_in = i_ff; pc_in = pc_ff; sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff;
      op_in = op_ff; row_in = row_ff; hit_in = hit_ff; kw_in = kw_ff;
      fvalid_in = fvalid_ff; rd_row_in = rd_row_ff;
      m_we = 1'b0; m_addr = MEM_AW'(pc_ff); m_wd = 8'd0;
      f_we = 1'b0; f_addr = rd_row_ff; f_wd = 64'd0;
      s_we = 1'b0; s_addr = sp_ff;
      case (cmd.op)
         OP_MEMWR: begin
            m_we = 1'b1; m_addr = MEM_AW'(mem_address); m_wd = mem_data;
            pc_in = 12'(PROGRAM_START); row_in = 64'd0; kw_in = 1'b0;
         end
         OP_ROWRD: begin
            f_addr = row_select[ROW_AW-1:0]; rd_row_in = row_select[ROW_AW-1:0];
            kw_in = 1'b0; row_in = 64'd0;
         end
         OP_LOAD_PC: begin
            if (func == FUNC_READ && 32'(row_select) < DISPLAY_HEIGHT) row_in = f_row;
         end
         OP_FETCH_HI: begin
            m_addr = MEM_AW'(pc_ff); row_in = 64'd0; kw_in = 1'b0; hit_in = 1'b0;
         end
         OP_FETCH_LO: begin
            m_addr = MEM_AW'(pc_ff + 12'd1); op_in[15:8] = m_rd;
         end
         OP_DECODE: begin
            op_in[7:0] = m_rd;
         end
         OP_CLR_ROW: begin
            fvalid_in = '0; pc_in = pc2;
         end
         OP_RET_RD: begin
            sp_in = sp_ff - 1'b1; s_addr = sp_ff - 1'b1;
         end
         OP_RET_WR: begin
            pc_in = s_rd;
         end
         OP_SPR_RD: begin
            m_addr = MEM_AW'(i_ff + 12'(cmd.cnt));
            if (cmd.cnt == 4'd0) pc_in = pc2;
         end
         OP_SPR_FRD: begin
            m_addr = MEM_AW'(i_ff + 12'(cmd.cnt));
            f_addr = spr_row; rd_row_in = spr_row;
         end
         OP_SPR_WR: begin
            f_addr = rd_row_ff; f_we = 1'b1;
            f_wd = f_row ^ spr_mask;
            fvalid_in[rd_row_ff] = 1'b1;
            if ((f_row & spr_mask) != 64'd0) hit_in = 1'b1;
            if (cmd.cnt == status.steps) v_in[15] = {7'd0, hit_in};
         end
         OP_BCD_WR: begin
            m_we = 1'b1; m_addr = MEM_AW'(i_ff + 12'(cmd.cnt));
            m_wd = (cmd.cnt == 4'd0) ? bcd_h : (cmd.cnt == 4'd1) ? bcd_t : bcd_o;
            if (cmd.cnt == 4'd0) pc_in = pc2;
         end
         OP_STR_WR: begin
            m_we = 1'b1; m_addr = MEM_AW'(i_ff + 12'(cmd.cnt)); m_wd = v_ff[cmd.cnt];
            if (cmd.cnt == 4'd0) pc_in = pc2;
         end
         OP_LD_RD: begin
            m_addr = MEM_AW'(i_ff + 12'(cmd.cnt));
            if (cmd.cnt == 4'd0) pc_in = pc2;
         end
         OP_LD_WR: begin
            v_in[cmd.cnt] = m_rd;
         end
         default: ;
      endcase
      if (cmd.op == OP_DECODE) begin
         // instructions without further steps execute here, opcode low byte arrives now
         logic [15:0] o;
         logic [3:0]  ox, oy;
         logic [7:0]  okk, ovx, ovy;
         logic [8:0]  osum;
         o = {op_ff[15:8], m_rd};
         ox = o[11:8]; oy = o[7:4]; okk = o[7:0];
         ovx = v_ff[ox]; ovy = v_ff[oy];
         osum = {1'b0, ovx} + {1'b0, ovy};
         pc_in = pc2;
         case (o[15:12])
            4'h0: if (o == 16'h00E0 || o == 16'h00EE) pc_in = pc_ff;
            4'h1: pc_in = o[11:0];
            4'h2: begin
               s_we = 1'b1; s_addr = sp_ff; pc_in = o[11:0]; sp_in = sp_ff + 1'b1;
            end
            4'h3: if (ovx == okk) pc_in = pc_ff + 12'd4;
            4'h4: if (ovx != okk) pc_in = pc_ff + 12'd4;
            4'h5: if (ovx == ovy) pc_in = pc_ff + 12'd4;
            4'h6: v_in[ox] = okk;
            4'h7: v_in[ox] = ovx + okk;
            4'h8: begin
               case (o[3:0])
                  4'h0: v_in[ox] = ovy;
                  4'h1: v_in[ox] = ovx | ovy;
                  4'h2: v_in[ox] = ovx & ovy;
                  4'h3: v_in[ox] = ovx ^ ovy;
                  4'h4: begin v_in[15] = {7'd0, osum[8]}; v_in[ox] = osum[7:0]; end
                  4'h5: begin v_in[15] = {7'd0, ovx > ovy}; v_in[ox] = ovx - ovy; end
                  4'h6: begin v_in[15] = {7'd0, ovx[0]}; v_in[ox] = ovx >> 1; end
                  4'h7: begin v_in[15] = {7'd0, ovy > ovx}; v_in[ox] = ovy - ovx; end
                  4'hE: begin v_in[15] = {7'd0, ovx[7]}; v_in[ox] = ovx << 1; end
                  default: ;
               endcase
            end
            4'h9: if (ovx != ovy) pc_in = pc_ff + 12'd4;
            4'hA: i_in = o[11:0];
            4'hB: pc_in = 12'(v_ff[0]) + o[11:0];
            4'hC: v_in[ox] = rnd_value & okk;
            4'hD: begin
               if (o[3:0] != 4'd0) pc_in = pc_ff;
               else v_in[15] = 8'd0;
            end
            4'hE: begin
               if ((okk == 8'h9E && keys_down[ovx[3:0]]) ||
                   (okk == 8'hA1 && !keys_down[ovx[3:0]])) pc_in = pc_ff + 12'd4;
            end
            4'hF: begin
               case (okk)
                  8'h07: v_in[ox] = dt_ff;
                  8'h0A: begin
                     if (keys_down == 16'd0) begin pc_in = pc_ff; kw_in = 1'b1; end
                     else v_in[ox] = 8'(low_key);
                  end
                  8'h15: dt_in = ovx;
                  8'h18: st_in = ovx;
                  8'h1E: i_in = i_ff + 12'(ovx);
                  8'h29: i_in = 12'(ovx) * 12'(GLYPH_BYTES);
                  8'h33, 8'h55, 8'h65: pc_in = pc_ff;
                  default: ;
               endcase
            end
            default: ;
         endcase
         if (o == 16'h00EE) begin sp_in = sp_ff - 1'b1; s_addr = sp_ff - 1'b1; end
      end
   end

   always_comb begin
      status.opcode   = op_ff;
      status.key_wait = kw_ff;
      status.multi    = 1'b0;
      status.steps    = 4'd0;
      case (op_ff[15:12])
         4'hD: begin status.multi = (n != 4'd0); status.steps = n - 4'd1; end
         4'hF: begin
            if (kk == 8'h33) begin status.multi = 1'b1; status.steps = 4'd2; end
            if (kk == 8'h55 || kk == 8'h65) begin status.multi = 1'b1; status.steps = x; end
         end
         default: ;
      endcase
      if (op_ff == 16'h00E0) status.multi = 1'b1;
      if (op_ff == 16'h00EE) status.multi = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 16; r++) v_ff[r] <= 8'd0;
         i_ff <= 12'd0; pc_ff <= 12'(PROGRAM_START); sp_ff <= '0;
         dt_ff <= 8'd0; st_ff <= 8'd0; fvalid_ff <= '0; kw_ff <= 1'b0;
         hit_ff <= 1'b0; row_ff <= 64'd0;
      end else begin
         for (int r = 0; r < 16; r++) v_ff[r] <= v_in[r];
         i_ff <= i_in; pc_ff <= pc_in; sp_ff <= sp_in;
         dt_ff <= dt_in; st_ff <= st_in; fvalid_ff <= fvalid_in; kw_ff <= kw_in;
         hit_ff <= hit_in; row_ff <= row_in;
      end
      op_ff <= op_in; rd_row_ff <= rd_row_in;
   end

   assign pc_out     = pc_ff;
   assign row_pixels = row_ff;
   assign flag_reg   = v_ff[15];
   assign sound_on   = (st_ff != 8'd0);
endmodule
`default_nettype wire

### hdl/c8_controller.sv
// c8_controller: sequencing state machine of the chip-8 instruction core
// depends on c8_pkg
`default_nettype none
module c8_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire c8_pkg::status_type status,
   output c8_pkg::cmd_type         cmd,
   output logic [1:0]              func
);
   import c8_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH_LO, S_DECODE, S_DISPATCH, S_RET, S_SPR_RD, S_SPR_FRD, S_SPR_WR,
      S_BCD, S_STR, S_LD_RD, S_LD_WR, S_READ, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] func_ff, func_in;
   logic rsp_ff, rsp_in;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_ff || rsp_ready);
   assign rsp_valid = rsp_ff;
   assign func      = func_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; func_in = func_ff; rsp_in = rsp_ff;
      cmd.op = OP_NONE; cmd.cnt = cnt_ff;
      if (rsp_ff && rsp_ready) rsp_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               func_in = req_func; cnt_in = 4'd0;
               case (req_func)
                  FUNC_WRITE: begin cmd.op = OP_MEMWR; rsp_in = 1'b1; end
                  FUNC_EXEC:  begin cmd.op = OP_FETCH_HI; state_in = S_FETCH_LO; end
                  FUNC_READ:  begin cmd.op = OP_ROWRD; state_in = S_READ; end
                  default:    begin cmd.op = OP_ROWRD; state_in = S_READ; end
               endcase
            end
         end
         S_READ: begin cmd.op = OP_LOAD_PC; state_in = S_DONE; end
         S_FETCH_LO: begin cmd.op = OP_FETCH_LO; state_in = S_DECODE; end
         S_DECODE: begin cmd.op = OP_DECODE; state_in = S_DISPATCH; end
         S_DISPATCH: begin
            cnt_in = 4'd0;
            if (!status.multi) begin cmd.op = OP_NONE; state_in = S_DONE; end
            else if (status.opcode == 16'h00E0) begin cmd.op = OP_CLR_ROW; state_in = S_DONE; end
            else if (status.opcode == 16'h00EE) state_in = S_RET;
            else if (status.opcode[15:12] == 4'hD) state_in = S_SPR_RD;
            else if (status.opcode[7:0] == 8'h33) state_in = S_BCD;
            else if (status.opcode[7:0] == 8'h55) state_in = S_STR;
            else state_in = S_LD_RD;
         end
         S_RET: begin cmd.op = OP_RET_WR; state_in = S_DONE; end
         S_SPR_RD: begin cmd.op = OP_SPR_RD; state_in = S_SPR_FRD; end
         S_SPR_FRD: begin cmd.op = OP_SPR_FRD; state_in = S_SPR_WR; end
         S_SPR_WR: begin
            cmd.op = OP_SPR_WR;
            if (cnt_ff == status.steps) state_in = S_DONE;
            else begin cnt_in = cnt_ff + 4'd1; state_in = S_SPR_RD; end
         end
         S_BCD, S_STR: begin
            cmd.op = (state_ff == S_BCD) ? OP_BCD_WR : OP_STR_WR;
            if (cnt_ff == status.steps) state_in = S_DONE;
            else cnt_in = cnt_ff + 4'd1;
         end
         S_LD_RD: begin cmd.op = OP_LD_RD; state_in = S_LD_WR; end
         S_LD_WR: begin
            cmd.op = OP_LD_WR;
            if (cnt_ff == status.steps) state_in = S_DONE;
            else begin cnt_in = cnt_ff + 4'd1; state_in = S_LD_RD; end
         end
         S_DONE: begin rsp_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= 4'd0; func_ff <= FUNC_WRITE; rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; func_ff <= func_in; rsp_ff <= rsp_in;
      end
   end
endmodule
`default_nettype wire

### hdl/chip8_instruction_core.sv
// chip8_instruction_core: top level, joins controller and datapath
// depends on c8_pkg, c8_controller, c8_datapath
//
// usage: items enter on the req_ channel (valid/ready), one result per
// transaction leaves on the rsp_ channel. the user makes csr_ writes of
// rnd_value while idle; the block does not enforce it. an execute item
// walks sprite rows, bcd and register stores and loads through the single
// memory port one byte per step. one item is in flight at a time; a
// result waits in the output register while the receiver stalls, and
// the next item is taken once that result is taken in the same cycle
// or earlier.
// synchronous reset clears registers, pc to program start, display via
// row valid bits; no clearing pass is needed.
`default_nettype none
module chip8_instruction_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [11:0] req_mem_address,
   input  wire logic [7:0]  req_mem_data,
   input  wire logic [15:0] req_keys_down,
   input  wire logic [4:0]  req_row_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_pc_out,
   output logic [63:0]      rsp_row_pixels,
   output logic [7:0]       rsp_flag_reg,
   output logic             rsp_key_wait,
   output logic             rsp_sound_on,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);
   import c8_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [1:0] func;
   logic [7:0] rnd_ff;
   logic [11:0] addr_ff;
   logic [7:0]  data_ff;
   logic [15:0] keys_ff;
   logic [4:0]  row_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) rnd_ff <= RND_RESET;
      else if (csr_valid) rnd_ff <= csr_data;
      if (req_valid && req_ready) begin
         addr_ff <= req_mem_address; data_ff <= req_mem_data;
         keys_ff <= req_keys_down; row_ff <= req_row_select;
      end
   end

   logic        first;
   logic [11:0] dp_addr;
   logic [7:0]  dp_data;
   logic [15:0] dp_keys;
   logic [4:0]  dp_row;
   assign first   = req_valid && req_ready;
   assign dp_addr = first ? req_mem_address : addr_ff;
   assign dp_data = first ? req_mem_data : data_ff;
   assign dp_keys = first ? req_keys_down : keys_ff;
   assign dp_row  = first ? req_row_select : row_ff;

   c8_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd), .func(func));

   c8_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .func(func),
      .mem_address(dp_addr), .mem_data(dp_data), .keys_down(dp_keys),
      .row_select(dp_row), .rnd_value(rnd_ff), .status(status),
      .pc_out(rsp_pc_out), .row_pixels(rsp_row_pixels), .flag_reg(rsp_flag_reg),
      .sound_on(rsp_sound_on));

   assign rsp_key_wait = status.key_wait;
endmodule
`default_nettype wire
